### rtl/gcst_pkg.sv
// Shared types, codes and reset values of the GPU constant shadow tracker.
`default_nettype none
package gcst_pkg;

   localparam int ALU_DWORDS_DEF           = 2048;
   localparam int FETCH_DWORDS_DEF         = 192;
   localparam int BOOL_WORDS_DEF           = 8;
   localparam int LOOP_WORDS_DEF           = 32;
   localparam int VERTEX_CONST_DWORDS_DEF  = 2;
   localparam int TEXTURE_CONST_DWORDS_DEF = 6;

   localparam logic [15:0] ALU_FIRST_RST   = 16'd16384;
   localparam logic [15:0] FETCH_FIRST_RST = 16'd18432;
   localparam logic [15:0] BOOL_FIRST_RST  = 16'd18688;
   localparam logic [15:0] LOOP_FIRST_RST  = 16'd18696;
   localparam logic [1:0]  VCODE_RST       = 2'd3;
   localparam logic [1:0]  TCODE_RST       = 2'd2;

   localparam logic [11:0] ALU_COUNT_MAX = 12'd4095;

   localparam logic [1:0] COV_UNDEF = 2'd0;
   localparam logic [1:0] COV_LIVE  = 2'd1;
   localparam logic [1:0] COV_WRONG = 2'd2;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_BEGIN = 2'd1,
      REQ_DRAW  = 2'd2,
      REQ_QUERY = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      CLS_ALU   = 3'd0,
      CLS_FETCH = 3'd1,
      CLS_BOOL  = 3'd2,
      CLS_LOOP  = 3'd3,
      CLS_NONE  = 3'd4
   } file_class_type;

   typedef enum logic [2:0] {
      CSR_ALU_FIRST   = 3'd0,
      CSR_FETCH_FIRST = 3'd1,
      CSR_BOOL_FIRST  = 3'd2,
      CSR_LOOP_FIRST  = 3'd3,
      CSR_VCODE       = 3'd4,
      CSR_TCODE       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0] alu_first;
      logic [15:0] fetch_first;
      logic [15:0] bool_first;
      logic [15:0] loop_first;
      logic [1:0]  vcode;
      logic [1:0]  tcode;
   } cfg_type;

   typedef struct packed {
      req_code_type   code;
      file_class_type cls;
      logic [15:0]    offset;
      logic [31:0]    value;
      logic [6:0]     slot;
      logic           tview;
   } work_item_type;

   typedef struct packed {
      file_class_type file_class;
      logic [6:0]     vfetch_live_count;
      logic [6:0]     vfetch_carried_count;
      logic [5:0]     tfetch_live_count;
      logic [5:0]     tfetch_carried_count;
      logic [11:0]    alu_defined_total;
      logic           alu_written_in_buffer;
      logic           fetch_valid;
      logic [31:0]    fetch_base;
      logic [23:0]    fetch_words;
      logic [1:0]     coverage;
      logic [31:0]    fetch_first_dword;
   } result_type;

endpackage
`default_nettype wire

### rtl/gcst_front.sv
// Front end: classifies requests into constant files and queues them for the back end.
`default_nettype none
module gcst_front
   import gcst_pkg::*;
#(
   parameter int ALU_DWORDS   = ALU_DWORDS_DEF,
   parameter int FETCH_DWORDS = FETCH_DWORDS_DEF,
   parameter int BOOL_WORDS   = BOOL_WORDS_DEF,
   parameter int LOOP_WORDS   = LOOP_WORDS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          clearing,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [1:0]    req_type,
   input  wire logic [15:0]   req_reg_addr,
   input  wire logic [31:0]   req_write_value,
   input  wire logic [6:0]    req_fetch_slot,
   input  wire logic          req_texture_view,
   output logic               item_valid,
   output work_item_type      item,
   input  wire logic          item_pop
);

   localparam logic [16:0] ALU_LEN   = 17'(ALU_DWORDS);
   localparam logic [16:0] FETCH_LEN = 17'(FETCH_DWORDS);
   localparam logic [16:0] BOOL_LEN  = 17'(BOOL_WORDS);
   localparam logic [16:0] LOOP_LEN  = 17'(LOOP_WORDS);

   work_item_type  entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   work_item_type  new_item;
   logic           accept;

   function automatic logic in_file(input logic [15:0] addr, input logic [15:0] first,
                                    input logic [16:0] len);
      logic [16:0] a;
      logic [16:0] f;
      a = {1'b0, addr};
      f = {1'b0, first};
      return (a >= f) && (a < f + len);
   endfunction

   always_comb begin
      new_item.code   = req_code_type'(req_type);
      new_item.value  = req_write_value;
      new_item.slot   = req_fetch_slot;
      new_item.tview  = req_texture_view;
      new_item.cls    = CLS_NONE;
      new_item.offset = '0;
      if (in_file(req_reg_addr, cfg.alu_first, ALU_LEN)) begin
         new_item.cls    = CLS_ALU;
         new_item.offset = req_reg_addr - cfg.alu_first;
      end else if (in_file(req_reg_addr, cfg.fetch_first, FETCH_LEN)) begin
         new_item.cls    = CLS_FETCH;
         new_item.offset = req_reg_addr - cfg.fetch_first;
      end else if (in_file(req_reg_addr, cfg.bool_first, BOOL_LEN)) begin
         new_item.cls    = CLS_BOOL;
         new_item.offset = req_reg_addr - cfg.bool_first;
      end else if (in_file(req_reg_addr, cfg.loop_first, LOOP_LEN)) begin
         new_item.cls    = CLS_LOOP;
         new_item.offset = req_reg_addr - cfg.loop_first;
      end
   end

   assign req_full   = (count_ff == 2'd2) || clearing;
   assign accept     = req_push && !req_full;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ item_pop;
      count_in  = count_ff + 2'(accept) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

### rtl/gcst_back.sv
// Back end: sequencer that updates the shadow state, answers draws and queries, queues results.
`default_nettype none
module gcst_back
   import gcst_pkg::*;
#(
   parameter int ALU_DWORDS           = ALU_DWORDS_DEF,
   parameter int FETCH_DWORDS         = FETCH_DWORDS_DEF,
   parameter int VERTEX_CONST_DWORDS  = VERTEX_CONST_DWORDS_DEF,
   parameter int TEXTURE_CONST_DWORDS = TEXTURE_CONST_DWORDS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   output logic               clearing,
   input  wire logic          item_valid,
   input  wire work_item_type item,
   output logic               item_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output result_type         rsp
);

   localparam int VSLOTS = FETCH_DWORDS / VERTEX_CONST_DWORDS;
   localparam int TSLOTS = FETCH_DWORDS / TEXTURE_CONST_DWORDS;
   localparam int AIW    = (ALU_DWORDS > 1) ? $clog2(ALU_DWORDS) : 1;
   localparam int FIW    = $clog2(FETCH_DWORDS);
   localparam int VSW    = (VSLOTS > 1) ? $clog2(VSLOTS) : 1;
   localparam int TSW    = (TSLOTS > 1) ? $clog2(TSLOTS) : 1;
   localparam int VCW    = $clog2(VSLOTS + 1);
   localparam int TCW    = $clog2(TSLOTS + 1);
   localparam int V_RECIP = (65536 + VERTEX_CONST_DWORDS - 1) / VERTEX_CONST_DWORDS;
   localparam int T_RECIP = (65536 + TEXTURE_CONST_DWORDS - 1) / TEXTURE_CONST_DWORDS;
   localparam logic [8:0] VSLOTS_W = 9'(VSLOTS);
   localparam logic [8:0] TSLOTS_W = 9'(TSLOTS);
   localparam logic [9:0] FETCH_W  = 10'(FETCH_DWORDS);
   localparam logic [9:0] VSTRIDE  = 10'(VERTEX_CONST_DWORDS);
   localparam logic [9:0] TSTRIDE  = 10'(TEXTURE_CONST_DWORDS);
   localparam logic [AIW-1:0] ALU_LAST = AIW'(ALU_DWORDS - 1);

   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b00000000001,
      ST_IDLE    = 11'b00000000010,
      ST_SIMPLE  = 11'b00000000100,
      ST_ALU_RD  = 11'b00000001000,
      ST_ALU_UPD = 11'b00000010000,
      ST_FW_WR   = 11'b00000100000,
      ST_FW_RD   = 11'b00001000000,
      ST_FW_UPD  = 11'b00010000000,
      ST_Q_RD1   = 11'b00100000000,
      ST_Q_RD2   = 11'b01000000000,
      ST_Q_DONE  = 11'b10000000000
   } state_type;

   state_type            state_ff, state_in;
   work_item_type        cur_ff, cur_in;
   logic [AIW-1:0]       clr_ff, clr_in;

   logic [FETCH_DWORDS-1:0] fdef_ff, fdef_in;
   logic [VSLOTS-1:0]    vlive_ff, vlive_in;
   logic [VSLOTS-1:0]    vinb_ff, vinb_in;
   logic [TSLOTS-1:0]    tlive_ff, tlive_in;
   logic [TSLOTS-1:0]    tinb_ff, tinb_in;
   logic [VCW-1:0]       vl_ff, vl_in, vc_ff, vc_in;
   logic [TCW-1:0]       tl_ff, tl_in, tc_ff, tc_in;
   logic [11:0]          alu_cnt_ff, alu_cnt_in;
   logic                 alu_any_ff, alu_any_in;
   logic [31:0]          bool0_ff, bool0_in;
   logic [31:0]          vfval_ff, vfval_in;

   logic                 alu_mem [ALU_DWORDS];
   logic                 alu_rd_ff;
   logic                 alu_we, alu_wd, alu_re;
   logic [AIW-1:0]       alu_wa, alu_ra;

   logic [31:0]          fv_mem [FETCH_DWORDS];
   logic [31:0]          rd_a_ff, rd_b_ff;
   logic                 fv_we, re_a, re_b;
   logic [FIW-1:0]       fv_wa, ra_a, ra_b;

   logic [VSLOTS-1:0]    vall;
   logic [TSLOTS-1:0]    tall;

   logic [FIW-1:0]       fidx;
   logic [FIW+16:0]      vprod, tprod;
   logic [7:0]           vq, tq;
   logic                 v_ok, t_ok;
   logic [VSW-1:0]       v_ix;
   logic [TSW-1:0]       t_ix;
   logic                 v_live_new, t_live_new;

   logic [9:0]           q_vfirst, q_vsec, q_tfirst, w_vfirst, w_tfirst;
   logic                 qv_ok, qt_ok, q_vsec_in;
   logic [VSW-1:0]       qv_ix;
   logic [TSW-1:0]       qt_ix;
   logic                 q_vlive;
   logic [31:0]          q_sec, q_tval;

   result_type           res;
   logic                 res_push;
   result_type           out_ff [2];
   logic                 owr_ff, owr_in, ord_ff, ord_in;
   logic [1:0]           ocnt_ff, ocnt_in;

   always_comb begin
      for (int v = 0; v < VSLOTS; v++) begin
         vall[v] = &fdef_ff[v*VERTEX_CONST_DWORDS +: VERTEX_CONST_DWORDS];
      end
      for (int t = 0; t < TSLOTS; t++) begin
         tall[t] = &fdef_ff[t*TEXTURE_CONST_DWORDS +: TEXTURE_CONST_DWORDS];
      end
   end

   // Slot of a fetch dword by reciprocal multiplication, exact for these narrow indexes.
   always_comb begin
      fidx       = cur_ff.offset[FIW-1:0];
      vprod      = (FIW+17)'(fidx) * (FIW+17)'(V_RECIP);
      tprod      = (FIW+17)'(fidx) * (FIW+17)'(T_RECIP);
      vq         = vprod[23:16];
      tq         = tprod[23:16];
      v_ok       = {1'b0, vq} < VSLOTS_W;
      t_ok       = {1'b0, tq} < TSLOTS_W;
      v_ix       = vq[VSW-1:0];
      t_ix       = tq[TSW-1:0];
      w_vfirst   = 10'(vq) * VSTRIDE;
      w_tfirst   = 10'(tq) * TSTRIDE;
      v_live_new = vall[v_ix] && (rd_a_ff[1:0] == cfg.vcode);
      t_live_new = tall[t_ix] && (rd_b_ff[1:0] == cfg.tcode);
   end

   always_comb begin
      qv_ok     = {2'b0, cur_ff.slot} < VSLOTS_W;
      qt_ok     = {2'b0, cur_ff.slot} < TSLOTS_W;
      qv_ix     = cur_ff.slot[VSW-1:0];
      qt_ix     = cur_ff.slot[TSW-1:0];
      q_vfirst  = 10'(cur_ff.slot) * VSTRIDE;
      q_vsec    = q_vfirst + 10'd1;
      q_tfirst  = 10'(cur_ff.slot) * TSTRIDE;
      q_vsec_in = q_vsec < FETCH_W;
      q_vlive   = qv_ok && vlive_ff[qv_ix];
      if (q_vsec_in) begin
         q_sec = fdef_ff[q_vsec[FIW-1:0]] ? rd_b_ff : 32'd0;
      end else begin
         q_sec = bool0_ff;
      end
      q_tval = (qt_ok && fdef_ff[q_tfirst[FIW-1:0]]) ? rd_a_ff : 32'd0;
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      clr_in     = clr_ff;
      fdef_in    = fdef_ff;
      vlive_in   = vlive_ff;
      vinb_in    = vinb_ff;
      tlive_in   = tlive_ff;
      tinb_in    = tinb_ff;
      vl_in      = vl_ff;
      vc_in      = vc_ff;
      tl_in      = tl_ff;
      tc_in      = tc_ff;
      alu_cnt_in = alu_cnt_ff;
      alu_any_in = alu_any_ff;
      bool0_in   = bool0_ff;
      vfval_in   = vfval_ff;
      item_pop   = 1'b0;
      alu_we     = 1'b0;
      alu_wd     = 1'b0;
      alu_wa     = cur_ff.offset[AIW-1:0];
      alu_re     = 1'b0;
      alu_ra     = cur_ff.offset[AIW-1:0];
      fv_we      = 1'b0;
      fv_wa      = fidx;
      re_a       = 1'b0;
      re_b       = 1'b0;
      ra_a       = w_vfirst[FIW-1:0];
      ra_b       = w_tfirst[FIW-1:0];
      res_push   = 1'b0;
      res        = '0;
      res.file_class = CLS_NONE;

      unique case (state_ff)
         ST_CLEAR: begin
            alu_we = 1'b1;
            alu_wa = clr_ff;
            clr_in = clr_ff + AIW'(1);
            if (clr_ff == ALU_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid && (ocnt_ff != 2'd2)) begin
               item_pop = 1'b1;
               cur_in   = item;
               if (item.code == REQ_QUERY) begin
                  state_in = ST_Q_RD1;
               end else if (item.code == REQ_WRITE && item.cls == CLS_ALU) begin
                  state_in = ST_ALU_RD;
               end else if (item.code == REQ_WRITE && item.cls == CLS_FETCH) begin
                  state_in = ST_FW_WR;
               end else begin
                  state_in = ST_SIMPLE;
               end
            end
         end
         ST_SIMPLE: begin
            res_push = 1'b1;
            state_in = ST_IDLE;
            case (cur_ff.code)
               REQ_WRITE: begin
                  res.file_class = cur_ff.cls;
                  if (cur_ff.cls == CLS_BOOL && cur_ff.offset == 16'd0) begin
                     bool0_in = cur_ff.value;
                  end
               end
               REQ_BEGIN: begin
                  vinb_in    = '0;
                  tinb_in    = '0;
                  vc_in      = vl_ff;
                  tc_in      = tl_ff;
                  alu_any_in = 1'b0;
               end
               REQ_DRAW: begin
                  res.vfetch_live_count     = 7'(vl_ff);
                  res.vfetch_carried_count  = 7'(vc_ff);
                  res.tfetch_live_count     = 6'(tl_ff);
                  res.tfetch_carried_count  = 6'(tc_ff);
                  res.alu_defined_total     = alu_cnt_ff;
                  res.alu_written_in_buffer = alu_any_ff;
               end
               default: begin
               end
            endcase
         end
         ST_ALU_RD: begin
            alu_re   = 1'b1;
            state_in = ST_ALU_UPD;
         end
         ST_ALU_UPD: begin
            alu_we     = 1'b1;
            alu_wd     = 1'b1;
            alu_any_in = 1'b1;
            if (!alu_rd_ff && alu_cnt_ff < ALU_COUNT_MAX) begin
               alu_cnt_in = alu_cnt_ff + 12'd1;
            end
            res.file_class = CLS_ALU;
            res_push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FW_WR: begin
            fv_we         = 1'b1;
            fdef_in[fidx] = 1'b1;
            state_in      = ST_FW_RD;
         end
         ST_FW_RD: begin
            re_a     = 1'b1;
            re_b     = 1'b1;
            state_in = ST_FW_UPD;
         end
         ST_FW_UPD: begin
            // Port A holds the first dword of the vertex constant, port B of the texture one.
            if (v_ok) begin
               vinb_in[v_ix]  = 1'b1;
               vlive_in[v_ix] = v_live_new;
               vl_in = vl_ff + VCW'(v_live_new) - VCW'(vlive_ff[v_ix]);
               vc_in = vc_ff - VCW'(vlive_ff[v_ix] && !vinb_ff[v_ix]);
            end
            if (t_ok) begin
               tinb_in[t_ix]  = 1'b1;
               tlive_in[t_ix] = t_live_new;
               tl_in = tl_ff + TCW'(t_live_new) - TCW'(tlive_ff[t_ix]);
               tc_in = tc_ff - TCW'(tlive_ff[t_ix] && !tinb_ff[t_ix]);
            end
            res.file_class = CLS_FETCH;
            res_push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_Q_RD1: begin
            re_a     = 1'b1;
            re_b     = 1'b1;
            ra_a     = q_vfirst[FIW-1:0];
            ra_b     = q_vsec[FIW-1:0];
            state_in = ST_Q_RD2;
         end
         ST_Q_RD2: begin
            vfval_in = (qv_ok && fdef_ff[q_vfirst[FIW-1:0]]) ? rd_a_ff : 32'd0;
            re_a     = 1'b1;
            ra_a     = q_tfirst[FIW-1:0];
            state_in = ST_Q_DONE;
         end
         ST_Q_DONE: begin
            res.fetch_valid = q_vlive;
            if (q_vlive) begin
               res.fetch_base  = vfval_ff & ~32'd3;
               res.fetch_words = q_sec[25:2];
            end
            if (cur_ff.tview) begin
               if (qt_ok) begin
                  res.fetch_first_dword = q_tval;
                  if (!tall[qt_ix]) begin
                     res.coverage = COV_UNDEF;
                  end else if (q_tval[1:0] == cfg.tcode) begin
                     res.coverage = COV_LIVE;
                  end else begin
                     res.coverage = COV_WRONG;
                  end
               end
            end else begin
               if (qv_ok) begin
                  res.fetch_first_dword = vfval_ff;
                  if (!vall[qv_ix]) begin
                     res.coverage = COV_UNDEF;
                  end else if (vfval_ff[1:0] == cfg.vcode) begin
                     res.coverage = COV_LIVE;
                  end else begin
                     res.coverage = COV_WRONG;
                  end
               end
            end
            res_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign clearing = (state_ff == ST_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         fdef_ff    <= '0;
         vlive_ff   <= '0;
         vinb_ff    <= '0;
         tlive_ff   <= '0;
         tinb_ff    <= '0;
         vl_ff      <= '0;
         vc_ff      <= '0;
         tl_ff      <= '0;
         tc_ff      <= '0;
         alu_cnt_ff <= '0;
         alu_any_ff <= 1'b0;
         bool0_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         fdef_ff    <= fdef_in;
         vlive_ff   <= vlive_in;
         vinb_ff    <= vinb_in;
         tlive_ff   <= tlive_in;
         tinb_ff    <= tinb_in;
         vl_ff      <= vl_in;
         vc_ff      <= vc_in;
         tl_ff      <= tl_in;
         tc_ff      <= tc_in;
         alu_cnt_ff <= alu_cnt_in;
         alu_any_ff <= alu_any_in;
         bool0_ff   <= bool0_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      vfval_ff <= vfval_in;
   end

   always_ff @(posedge clock) begin
      if (alu_we) begin
         alu_mem[alu_wa] <= alu_wd;
      end
      if (alu_re) begin
         alu_rd_ff <= alu_mem[alu_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (fv_we) begin
         fv_mem[fv_wa] <= cur_ff.value;
      end
      if (re_a) begin
         rd_a_ff <= fv_mem[ra_a];
      end
      if (re_b) begin
         rd_b_ff <= fv_mem[ra_b];
      end
   end

   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp       = out_ff[ord_ff];

   always_comb begin
      owr_in  = owr_ff ^ res_push;
      ord_in  = ord_ff ^ (rsp_pop && !rsp_empty);
      ocnt_in = ocnt_ff + 2'(res_push) - 2'(rsp_pop && !rsp_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         out_ff[owr_ff] <= res;
      end
   end

endmodule
`default_nettype wire

### rtl/gpu_constant_shadow_tracker.sv
// Top level of the GPU constant shadow tracker: register port, front end and back end.
`default_nettype none
// From its idle state the back-end sequencer runs the simple state (begin-buffer, draw,
// non-ALU non-fetch writes), ALU read and update (ALU writes), fetch write, read and
// update (fetch writes) or two reads and done (queries), then takes the next request.
// The steps are set by the single write port and the two read ports of the fetch value
// memory and the read-then-write pass over the ALU defined-bit memory. Two-entry queues
// on both sides let requests and results flow while the back end works. After reset,
// req_full stays high while a pass zeroes ALU_DWORDS (2048 by default) ALU defined bits.
module gpu_constant_shadow_tracker
   import gcst_pkg::*;
#(
   parameter int ALU_DWORDS           = ALU_DWORDS_DEF,
   parameter int FETCH_DWORDS         = FETCH_DWORDS_DEF,
   parameter int BOOL_WORDS           = BOOL_WORDS_DEF,
   parameter int LOOP_WORDS           = LOOP_WORDS_DEF,
   parameter int VERTEX_CONST_DWORDS  = VERTEX_CONST_DWORDS_DEF,
   parameter int TEXTURE_CONST_DWORDS = TEXTURE_CONST_DWORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_reg_addr,
   input  wire logic [31:0] req_write_value,
   input  wire logic [6:0]  req_fetch_slot,
   input  wire logic        req_texture_view,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_file_class,
   output logic [6:0]       rsp_vfetch_live_count,
   output logic [6:0]       rsp_vfetch_carried_count,
   output logic [5:0]       rsp_tfetch_live_count,
   output logic [5:0]       rsp_tfetch_carried_count,
   output logic [11:0]      rsp_alu_defined_total,
   output logic             rsp_alu_written_in_buffer,
   output logic             rsp_fetch_valid,
   output logic [31:0]      rsp_fetch_base,
   output logic [23:0]      rsp_fetch_words,
   output logic [1:0]       rsp_coverage,
   output logic [31:0]      rsp_fetch_first_dword,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type        cfg_ff, cfg_in;
   logic           clearing;
   logic           item_valid;
   logic           item_pop;
   work_item_type  item;
   result_type     rsp;
   logic           csr_wr;
   csr_index_type  csr_ix;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_ix     = csr_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_ix)
            CSR_ALU_FIRST:   cfg_in.alu_first   = csr_pwdata[15:0];
            CSR_FETCH_FIRST: cfg_in.fetch_first = csr_pwdata[15:0];
            CSR_BOOL_FIRST:  cfg_in.bool_first  = csr_pwdata[15:0];
            CSR_LOOP_FIRST:  cfg_in.loop_first  = csr_pwdata[15:0];
            CSR_VCODE:       cfg_in.vcode       = csr_pwdata[1:0];
            CSR_TCODE:       cfg_in.tcode       = csr_pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_ix)
         CSR_ALU_FIRST:   csr_prdata = {16'd0, cfg_ff.alu_first};
         CSR_FETCH_FIRST: csr_prdata = {16'd0, cfg_ff.fetch_first};
         CSR_BOOL_FIRST:  csr_prdata = {16'd0, cfg_ff.bool_first};
         CSR_LOOP_FIRST:  csr_prdata = {16'd0, cfg_ff.loop_first};
         CSR_VCODE:       csr_prdata = {30'd0, cfg_ff.vcode};
         CSR_TCODE:       csr_prdata = {30'd0, cfg_ff.tcode};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alu_first   <= ALU_FIRST_RST;
         cfg_ff.fetch_first <= FETCH_FIRST_RST;
         cfg_ff.bool_first  <= BOOL_FIRST_RST;
         cfg_ff.loop_first  <= LOOP_FIRST_RST;
         cfg_ff.vcode       <= VCODE_RST;
         cfg_ff.tcode       <= TCODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcst_front #(
      .ALU_DWORDS   (ALU_DWORDS),
      .FETCH_DWORDS (FETCH_DWORDS),
      .BOOL_WORDS   (BOOL_WORDS),
      .LOOP_WORDS   (LOOP_WORDS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .clearing         (clearing),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_reg_addr     (req_reg_addr),
      .req_write_value  (req_write_value),
      .req_fetch_slot   (req_fetch_slot),
      .req_texture_view (req_texture_view),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop)
   );

   gcst_back #(
      .ALU_DWORDS           (ALU_DWORDS),
      .FETCH_DWORDS         (FETCH_DWORDS),
      .VERTEX_CONST_DWORDS  (VERTEX_CONST_DWORDS),
      .TEXTURE_CONST_DWORDS (TEXTURE_CONST_DWORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_file_class            = rsp.file_class;
   assign rsp_vfetch_live_count     = rsp.vfetch_live_count;
   assign rsp_vfetch_carried_count  = rsp.vfetch_carried_count;
   assign rsp_tfetch_live_count     = rsp.tfetch_live_count;
   assign rsp_tfetch_carried_count  = rsp.tfetch_carried_count;
   assign rsp_alu_defined_total     = rsp.alu_defined_total;
   assign rsp_alu_written_in_buffer = rsp.alu_written_in_buffer;
   assign rsp_fetch_valid           = rsp.fetch_valid;
   assign rsp_fetch_base            = rsp.fetch_base;
   assign rsp_fetch_words           = rsp.fetch_words;
   assign rsp_coverage              = rsp.coverage;
   assign rsp_fetch_first_dword     = rsp.fetch_first_dword;

endmodule
`default_nettype wire

### tb/gpu_constant_shadow_tracker_tb.sv
// Self-checking testbench for the GPU constant shadow tracker.
`default_nettype none
module gpu_constant_shadow_tracker_tb;
   import gcst_pkg::*;

   localparam int NALU = 2048;
   localparam int NFETCH = 192;
   localparam int NBOOL = 8;
   localparam int NLOOP = 32;
   localparam int VSTRIDE = 2;
   localparam int TSTRIDE = 6;
   localparam int NWORDS = NALU + NFETCH + NBOOL + NLOOP;
   localparam int NVSLOT = NFETCH / VSTRIDE;
   localparam int NTSLOT = NFETCH / TSTRIDE;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [31:0] value;
      logic [6:0]  slot;
      logic        tview;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_type = '0;
   logic [15:0] req_reg_addr = '0;
   logic [31:0] req_write_value = '0;
   logic [6:0]  req_fetch_slot = '0;
   logic        req_texture_view = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_file_class;
   logic [6:0]  rsp_vfetch_live_count, rsp_vfetch_carried_count;
   logic [5:0]  rsp_tfetch_live_count, rsp_tfetch_carried_count;
   logic [11:0] rsp_alu_defined_total;
   logic        rsp_alu_written_in_buffer, rsp_fetch_valid;
   logic [31:0] rsp_fetch_base;
   logic [23:0] rsp_fetch_words;
   logic [1:0]  rsp_coverage;
   logic [31:0] rsp_fetch_first_dword;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gpu_constant_shadow_tracker uut (.*);

   always #10 clock = ~clock;

   // Shadow state of the block.
   logic [15:0] file_base [4];
   logic [1:0]  vcode, tcode;
   logic [31:0] shadow_value [NWORDS];
   logic        shadow_defined [NWORDS];
   logic        vlive [NVSLOT], vinbuf [NVSLOT];
   logic        tlive [NTSLOT], tinbuf [NTSLOT];
   logic [11:0] alu_count;
   logic        alu_touched;

   request_type pending_requests [$];
   result_type  expected_results [$];
   int          errors = 0;
   int          sent = 0, received = 0;
   int          idle_pct = 0, stall_pct = 0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;
   int          kind_seen [4] = '{0, 0, 0, 0};

   function automatic logic [1:0] fetch_coverage(int first, int dwords, logic [1:0] want);
      for (int d = 0; d < dwords; d++)
         if (!shadow_defined[NALU + first + d]) return COV_UNDEF;
      return (shadow_value[NALU + first][1:0] == want) ? COV_LIVE : COV_WRONG;
   endfunction

   function automatic result_type shadow_apply(request_type r);
      result_type res;
      int lens [4];
      int offs [4];
      int idx, cls, d, v, t, vl, vc, tl, tc;
      lens = '{NALU, NFETCH, NBOOL, NLOOP};
      offs = '{0, NALU, NALU + NFETCH, NALU + NFETCH + NBOOL};
      res = '0;
      res.file_class = CLS_NONE;
      cls = 4;
      idx = 0;
      case (r.kind)
         REQ_WRITE: begin
            for (int f = 0; f < 4; f++)
               if (cls == 4 && int'(r.addr) >= int'(file_base[f]) &&
                   int'(r.addr) < int'(file_base[f]) + lens[f]) begin
                  cls = f;
                  idx = offs[f] + int'(r.addr) - int'(file_base[f]);
               end
            res.file_class = file_class_type'(cls);
            if (cls != 4) begin
               if (cls == 0) begin
                  if (!shadow_defined[idx] && alu_count < ALU_COUNT_MAX)
                     alu_count = alu_count + 12'd1;
                  alu_touched = 1'b1;
               end
               shadow_value[idx] = r.value;
               shadow_defined[idx] = 1'b1;
               if (cls == 1) begin
                  d = idx - NALU;
                  v = d / VSTRIDE;
                  t = d / TSTRIDE;
                  if (v < NVSLOT) begin
                     vinbuf[v] = 1'b1;
                     vlive[v] = fetch_coverage(v * VSTRIDE, VSTRIDE, vcode) == COV_LIVE;
                  end
                  if (t < NTSLOT) begin
                     tinbuf[t] = 1'b1;
                     tlive[t] = fetch_coverage(t * TSTRIDE, TSTRIDE, tcode) == COV_LIVE;
                  end
               end
            end
         end
         REQ_BEGIN: begin
            foreach (vinbuf[i]) vinbuf[i] = 1'b0;
            foreach (tinbuf[i]) tinbuf[i] = 1'b0;
            alu_touched = 1'b0;
         end
         REQ_DRAW: begin
            vl = 0; vc = 0; tl = 0; tc = 0;
            foreach (vlive[i]) if (vlive[i]) begin vl++; if (!vinbuf[i]) vc++; end
            foreach (tlive[i]) if (tlive[i]) begin tl++; if (!tinbuf[i]) tc++; end
            res.vfetch_live_count = 7'(vl);
            res.vfetch_carried_count = 7'(vc);
            res.tfetch_live_count = 6'(tl);
            res.tfetch_carried_count = 6'(tc);
            res.alu_defined_total = alu_count;
            res.alu_written_in_buffer = alu_touched;
         end
         default: begin
            if (r.slot < NVSLOT && vlive[r.slot]) begin
               idx = NALU + r.slot * VSTRIDE;
               res.fetch_valid = 1'b1;
               res.fetch_base = shadow_value[idx] & ~32'h3;
               res.fetch_words = (idx + 1 < NWORDS) ? shadow_value[idx + 1][25:2] : '0;
            end
            if (r.tview) begin
               if (r.slot < NTSLOT) begin
                  res.coverage = fetch_coverage(r.slot * TSTRIDE, TSTRIDE, tcode);
                  res.fetch_first_dword = shadow_value[NALU + r.slot * TSTRIDE];
               end
            end else if (r.slot < NVSLOT) begin
               res.coverage = fetch_coverage(r.slot * VSTRIDE, VSTRIDE, vcode);
               res.fetch_first_dword = shadow_value[NALU + r.slot * VSTRIDE];
            end
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH response %0d %s: got %0h expected %0h", received, what, got, want);
      errors++;
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_results.push_back(shadow_apply(pending_requests.pop_front()));
            sent++;
         end
         if (!(req_push && req_full)) begin
            if (pending_requests.size() > 0 &&
                $urandom_range(99) >= idle_pct) begin
               req_push <= 1'b1;
               req_type <= pending_requests[0].kind;
               req_reg_addr <= pending_requests[0].addr;
               req_write_value <= pending_requests[0].value;
               req_fetch_slot <= pending_requests[0].slot;
               req_texture_view <= pending_requests[0].tview;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold, counted down here.
   always @(posedge clock) begin
      if (hold_cycles > 0)
         hold_cycles <= hold_cycles - 1;
   end

   // Monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            result_type want;
            received++;
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing expected", 32'd0, 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_file_class != want.file_class)
                  report_mismatch("file_class", rsp_file_class, want.file_class);
               if (rsp_vfetch_live_count != want.vfetch_live_count)
                  report_mismatch("vertex live count", rsp_vfetch_live_count,
                                  want.vfetch_live_count);
               if (rsp_vfetch_carried_count != want.vfetch_carried_count)
                  report_mismatch("vertex carried count", rsp_vfetch_carried_count,
                                  want.vfetch_carried_count);
               if (rsp_tfetch_live_count != want.tfetch_live_count)
                  report_mismatch("texture live count", rsp_tfetch_live_count,
                                  want.tfetch_live_count);
               if (rsp_tfetch_carried_count != want.tfetch_carried_count)
                  report_mismatch("texture carried count", rsp_tfetch_carried_count,
                                  want.tfetch_carried_count);
               if (rsp_alu_defined_total != want.alu_defined_total)
                  report_mismatch("alu_defined_total", rsp_alu_defined_total,
                                  want.alu_defined_total);
               if (rsp_alu_written_in_buffer != want.alu_written_in_buffer)
                  report_mismatch("alu_written", rsp_alu_written_in_buffer,
                                  want.alu_written_in_buffer);
               if (rsp_fetch_valid != want.fetch_valid)
                  report_mismatch("fetch_valid", rsp_fetch_valid, want.fetch_valid);
               if (rsp_fetch_base != want.fetch_base)
                  report_mismatch("fetch_base", rsp_fetch_base, want.fetch_base);
               if (rsp_fetch_words != want.fetch_words)
                  report_mismatch("fetch_words", rsp_fetch_words, want.fetch_words);
               if (rsp_coverage != want.coverage)
                  report_mismatch("coverage", rsp_coverage, want.coverage);
               if (rsp_fetch_first_dword != want.fetch_first_dword)
                  report_mismatch("first word", rsp_fetch_first_dword,
                                  want.fetch_first_dword);
            end
         end
         rsp_pop <= (hold_cycles == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on cycles without any accepted request or response outside a receiver hold.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (hold_cycles > 0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d responses outstanding", expected_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic add_request(logic [1:0] k, int a, logic [31:0] v, int s, int tv);
      request_type r;
      r.kind = k; r.addr = 16'(a); r.value = v; r.slot = 7'(s); r.tview = 1'(tv);
      pending_requests.push_back(r);
      kind_seen[k]++;
   endtask

   task automatic write_csr(csr_index_type index, int data);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 5'(index) << 2; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (index)
         CSR_VCODE: vcode = data[1:0];
         CSR_TCODE: tcode = data[1:0];
         default: file_base[index] = data[15:0];
      endcase
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || expected_results.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Random content aimed most often at the fetch file so constants come alive.
   task automatic add_random(int count);
      logic [31:0] v;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         v = $urandom;
         if (pick < 40) begin
            if ($urandom_range(1)) v[1:0] = $urandom_range(1) ? vcode : tcode;
            add_request(REQ_WRITE, file_base[1] + $urandom_range(NFETCH - 1), v, $urandom,
                        $urandom);
         end else if (pick < 55) begin
            add_request(REQ_WRITE, file_base[0] + $urandom_range(NALU - 1), v, $urandom,
                        $urandom);
         end else if (pick < 62) begin
            add_request(REQ_WRITE, file_base[2 + $urandom_range(1)] + $urandom_range(40),
                        v, $urandom, $urandom);
         end else if (pick < 66) begin
            add_request(REQ_WRITE, $urandom, v, $urandom, $urandom);
         end else if (pick < 72) begin
            add_request(REQ_BEGIN, $urandom, v, $urandom, $urandom);
         end else if (pick < 82) begin
            add_request(REQ_DRAW, $urandom, v, $urandom, $urandom);
         end else begin
            add_request(REQ_QUERY, $urandom, v,
                        $urandom_range(1) ? $urandom_range(NVSLOT - 1) : $urandom, $urandom);
         end
      end
   endtask

   initial begin
      file_base = '{ALU_FIRST_RST, FETCH_FIRST_RST, BOOL_FIRST_RST, LOOP_FIRST_RST};
      vcode = VCODE_RST;
      tcode = TCODE_RST;
      foreach (shadow_value[i]) begin shadow_value[i] = '0; shadow_defined[i] = 1'b0; end
      foreach (vlive[i]) begin vlive[i] = 1'b0; vinbuf[i] = 1'b0; end
      foreach (tlive[i]) begin tlive[i] = 1'b0; tinbuf[i] = 1'b0; end
      alu_count = '0;
      alu_touched = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes of the fields and every request kind.
      add_request(REQ_DRAW, 'hFFFF, 32'hFFFFFFFF, 'h7F, 1);
      add_request(REQ_QUERY, 0, 0, 0, 0);
      add_request(REQ_QUERY, 0, 0, 'h7F, 1);
      add_request(REQ_WRITE, 0, 32'hFFFFFFFF, 0, 0);
      add_request(REQ_WRITE, 'hFFFF, 32'hFFFFFFFF, 'h7F, 1);
      add_request(REQ_WRITE, int'(ALU_FIRST_RST), 32'h1, 0, 0);
      add_request(REQ_WRITE, int'(ALU_FIRST_RST), 32'h2, 0, 0);
      add_request(REQ_WRITE, ALU_FIRST_RST + NALU - 1, 32'h3, 0, 0);
      add_request(REQ_WRITE, int'(FETCH_FIRST_RST), 32'hFFFFFFFF, 0, 0);
      add_request(REQ_WRITE, FETCH_FIRST_RST + 1, 32'hFFFFFFFF, 0, 0);
      for (int i = 2; i < 6; i++)
         add_request(REQ_WRITE, FETCH_FIRST_RST + i, 32'h12345672, 0, 0);
      add_request(REQ_WRITE, FETCH_FIRST_RST + NFETCH - 1, 32'h0000_0003, 0, 0);
      add_request(REQ_WRITE, BOOL_FIRST_RST + NBOOL - 1, 32'hA5, 0, 0);
      add_request(REQ_WRITE, LOOP_FIRST_RST + NLOOP - 1, 32'h5A, 0, 0);
      add_request(REQ_WRITE, LOOP_FIRST_RST + NLOOP, 32'h5A, 0, 0);
      add_request(REQ_DRAW, 0, 0, 0, 0);
      add_request(REQ_QUERY, 0, 0, 0, 0);
      add_request(REQ_QUERY, 0, 0, 0, 1);
      add_request(REQ_QUERY, 0, 0, NVSLOT - 1, 0);
      add_request(REQ_QUERY, 0, 0, NTSLOT, 1);
      add_request(REQ_BEGIN, 0, 0, 0, 0);
      add_request(REQ_DRAW, 0, 0, 0, 0);
      wait_drained();

      // No idling.
      add_random(300);
      wait_drained();

      // Overlapping files and alternative type codes.
      write_csr(CSR_ALU_FIRST, 100);
      write_csr(CSR_FETCH_FIRST, 2100);
      write_csr(CSR_BOOL_FIRST, 2200);
      write_csr(CSR_LOOP_FIRST, 2205);
      write_csr(CSR_VCODE, 0);
      write_csr(CSR_TCODE, 1);
      idle_pct = 56;
      add_random(300);
      wait_drained();

      // Receiver holds off while the sender keeps offering requests.
      idle_pct = 0;
      add_random(40);
      hold_cycles = 300;
      wait (hold_cycles == 0);
      wait_drained();

      // Extreme addresses for the files.
      write_csr(CSR_ALU_FIRST, 'hFFFF);
      write_csr(CSR_FETCH_FIRST, 0);
      write_csr(CSR_BOOL_FIRST, 'hFFF8);
      write_csr(CSR_LOOP_FIRST, 0);
      write_csr(CSR_VCODE, 3);
      write_csr(CSR_TCODE, 3);
      stall_pct = 56;
      add_random(400);
      wait_drained();

      write_csr(CSR_ALU_FIRST, int'(ALU_FIRST_RST));
      write_csr(CSR_FETCH_FIRST, int'(FETCH_FIRST_RST));
      write_csr(CSR_BOOL_FIRST, int'(BOOL_FIRST_RST));
      write_csr(CSR_LOOP_FIRST, int'(LOOP_FIRST_RST));
      write_csr(CSR_VCODE, 2);
      write_csr(CSR_TCODE, 0);
      idle_pct = 8;
      stall_pct = 8;
      add_random(400);
      wait_drained();
      idle_pct = 0;
      stall_pct = 0;
      add_random(360);
      wait_drained();

      $display("Sent %0d requests (%0d writes, %0d begins, %0d draws, %0d queries).",
               sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("Received %0d responses over several register settings.", received);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
rtl/gcst_pkg.sv
rtl/gcst_front.sv
rtl/gcst_back.sv
rtl/gpu_constant_shadow_tracker.sv
tb/gpu_constant_shadow_tracker_tb.sv
